@@ src/max_delay_phase_signal_controller_top_macros.svh @@
// Assertion macros for the max-delay signal controller checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MAX_DELAY_PHASE_SIGNAL_CONTROLLER_TOP_MACROS_SVH
`define MAX_DELAY_PHASE_SIGNAL_CONTROLLER_TOP_MACROS_SVH

// Property holds at every clock edge outside reset.
`define MDPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MDPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mdpsc_pkg.sv @@
// Shared types and constants for the max-delay signal controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mdpsc_pkg;

  localparam int LINKS       = 16;
  localparam int BATCHES     = 16;
  localparam int LINK_IDX_W  = 4;
  localparam int BATCH_IDX_W = 4;
  localparam int CNT_W       = 5;   // holds 0..16
  localparam int PATTERN_W   = 2 * LINKS;
  localparam int TIME_W      = 16;
  localparam int VEH_W       = 8;
  localparam int PROD_W      = VEH_W + TIME_W;
  localparam int QUO_W       = PROD_W - 2;  // x/5 < x/4
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // x/5 == (x * DIV5_MULT) >> DIV5_SHIFT for every x below 2^32
  localparam logic [31:0] DIV5_MULT  = 32'hCCCC_CCCD;
  localparam int          DIV5_SHIFT = 34;

  // per-link signal codes
  localparam logic [1:0] SIG_RED        = 2'd0;
  localparam logic [1:0] SIG_YELLOW     = 2'd1;
  localparam logic [1:0] SIG_PERMISSIVE = 2'd2;
  localparam logic [1:0] SIG_GREEN      = 2'd3;

  // config reset values
  localparam logic [TIME_W-1:0]    RST_MIN_GREEN   = 16'd100;
  localparam logic [TIME_W-1:0]    RST_MAX_GREEN   = 16'd600;
  localparam logic [TIME_W-1:0]    RST_YELLOW_TIME = 16'd30;
  localparam logic [TIME_W-1:0]    RST_RED_TIME    = 16'd20;
  localparam logic [CNT_W-1:0]     RST_NUM_LINKS   = 5'd16;
  localparam logic [CNT_W-1:0]     RST_NUM_BATCHES = 5'd1;
  localparam logic [PATTERN_W-1:0] RST_INIT_STATE  = '0;

  typedef enum logic [1:0] {
    OP_LOAD         = 2'd0,
    OP_REPORT       = 2'd1,
    OP_INTERVAL_END = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_GREEN       = 3'd0,
    CFG_MAX_GREEN       = 3'd1,
    CFG_YELLOW_TIME     = 3'd2,
    CFG_RED_TIME        = 3'd3,
    CFG_RIGHT_TURN_MASK = 3'd4,
    CFG_NUM_LINKS       = 3'd5,
    CFG_NUM_BATCHES     = 3'd6,
    CFG_INITIAL_STATE   = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ACCUM,
    ST_CMP,
    ST_MUL,
    ST_DIV,
    ST_DECIDE,
    ST_GREEN_END,
    ST_ADVANCE
  } state_e;

  typedef struct packed {
    logic                   load_we;
    logic                   report_we;
    logic                   lanes_clr;
    logic                   lanes_acc;
    logic                   cmp_en;
    logic                   cmp_first;
    logic                   mul_en;
    logic                   div_en;
    logic                   decide_en;
    logic                   green_end;
    logic                   phase_adv;
    logic [LINK_IDX_W-1:0]  link_idx;
    logic [BATCH_IDX_W-1:0] batch_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic                   phase_green;
    logic [BATCH_IDX_W-1:0] last_batch_idx;
  } dp_status_t;

endpackage

@@ src/mdpsc_ctrl.sv @@
// Sequencer for the signal controller: beat dispatch, link sweep, batch compare.
// Depends on mdpsc_pkg.
`timescale 1ns / 1ps

module mdpsc_ctrl import mdpsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] operation_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy
);

  state_e                 state_q, state_d;
  logic [LINK_IDX_W-1:0]  link_q, link_d;
  logic [BATCH_IDX_W-1:0] batch_q, batch_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      link_q  <= '0;
      batch_q <= '0;
    end else begin
      state_q <= state_d;
      link_q  <= link_d;
      batch_q <= batch_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    link_d          = link_q;
    batch_d         = batch_q;
    cmd_o           = '0;
    cmd_o.link_idx  = link_q;
    cmd_o.batch_idx = batch_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (op_e'(operation_i))
            OP_LOAD:         cmd_o.load_we = 1'b1;
            OP_REPORT:       cmd_o.report_we = 1'b1;
            OP_INTERVAL_END: state_d = status_i.phase_green ? ST_INIT : ST_ADVANCE;
            default:         ;
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.lanes_clr = 1'b1;
        link_d          = '0;
        state_d         = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd_o.lanes_acc = 1'b1;
        if (link_q == LINK_IDX_W'(LINKS - 1)) begin
          batch_d = '0;
          state_d = ST_CMP;
        end else begin
          link_d = link_q + 1'b1;
        end
      end
      ST_CMP: begin
        cmd_o.cmp_en    = 1'b1;
        cmd_o.cmp_first = (batch_q == '0);
        if (batch_q == status_i.last_batch_idx) begin
          state_d = ST_MUL;
        end else begin
          batch_d = batch_q + 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        state_d      = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide_en = 1'b1;
        state_d         = ST_GREEN_END;
      end
      ST_GREEN_END: begin
        cmd_o.green_end = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_ADVANCE: begin
        cmd_o.phase_adv = 1'b1;
        state_d         = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

@@ src/mdpsc_datapath.sv @@
// Datapath: config registers, link/batch tables, per-batch lanes, green timing,
// signal patterns and the result register. Depends on mdpsc_pkg.
`timescale 1ns / 1ps

module mdpsc_datapath import mdpsc_pkg::*; #(
  parameter int DELAY_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [3:0]             index_i,
  input  logic [15:0]            batch_mask_i,
  input  logic [31:0]            link_delay_i,
  input  logic [VEH_W-1:0]       vehicle_count_i,
  input  dp_cmd_t                cmd_i,
  output dp_status_t             status_o,
  output logic                   done_o,
  output logic [PATTERN_W-1:0]   signal_state_o,
  output logic [TIME_W-1:0]      duration_o,
  output logic [1:0]             phase_o,
  output logic [BATCH_IDX_W-1:0] chosen_batch_o,
  output logic                   green_continued_o
);

  // only the low DW bits (at most 32) of a report reach the store
  localparam int DW    = (DELAY_WIDTH < 32) ? DELAY_WIDTH : 32;
  localparam int SUM_W = DW + LINK_IDX_W;

  // config
  logic [TIME_W-1:0] min_green_q, max_green_q, yellow_time_q, red_time_q;
  logic [LINKS-1:0]  right_mask_q;
  logic [CNT_W-1:0]  num_links_q, num_batches_q;

  // controller state
  phase_e                 cur_phase_q;
  logic [PATTERN_W-1:0]   cur_pat_q, ngp_q, ngp_d;
  logic [TIME_W-1:0]      ngd_q, ngd_d;
  logic [BATCH_IDX_W-1:0] last_batch_q;

  // tables
  logic [LINKS-1:0] batch_q [BATCHES];
  logic [DW-1:0]    delay_q [LINKS];
  logic [VEH_W-1:0] veh_q   [LINKS];

  // per-batch lanes
  logic [SUM_W-1:0] lane_d_q    [BATCHES];
  logic [CNT_W-1:0] lane_ones_q [BATCHES];
  logic [VEH_W-1:0] lane_veh_q  [BATCHES];

  // running best
  logic [SUM_W-1:0]       best_d_q;
  logic [CNT_W-1:0]       best_ones_q;
  logic [VEH_W-1:0]       best_veh_q;
  logic [BATCH_IDX_W-1:0] best_idx_q;

  logic [PROD_W-1:0] prod_q;
  logic [QUO_W-1:0]  quo_q;

  logic                   done_q, cont_q;
  logic [PATTERN_W-1:0]   shown_q;
  logic [TIME_W-1:0]      dur_q;
  logic [1:0]             ph_q;
  logic [BATCH_IDX_W-1:0] chosen_q;

  logic [CNT_W-1:0]     nl, nb;
  logic [LINKS-1:0]     link_en;
  logic [PATTERN_W-1:0] lmask, yel_end_pat, grn_end_pat;
  logic                 need_yellow;
  logic [PROD_W+31:0]   div_full;

  // effective link and batch counts
  always_comb begin
    nl = (num_links_q > CNT_W'(LINKS)) ? CNT_W'(LINKS) : num_links_q;
    if (num_batches_q == '0) begin
      nb = CNT_W'(1);
    end else if (num_batches_q > CNT_W'(BATCHES)) begin
      nb = CNT_W'(BATCHES);
    end else begin
      nb = num_batches_q;
    end
  end

  always_comb begin
    for (int k = 0; k < LINKS; k++) begin
      link_en[k]         = (CNT_W'(k) < nl);
      lmask[2*k +: 2]    = {2{link_en[k]}};
    end
  end

  assign status_o.phase_green    = (cur_phase_q == PH_GREEN);
  assign status_o.last_batch_idx = nb[BATCH_IDX_W-1:0] - 1'b1;

  // config port; initial_state also reloads the shown pattern
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_green_q   <= RST_MIN_GREEN;
      max_green_q   <= RST_MAX_GREEN;
      yellow_time_q <= RST_YELLOW_TIME;
      red_time_q    <= RST_RED_TIME;
      right_mask_q  <= '0;
      num_links_q   <= RST_NUM_LINKS;
      num_batches_q <= RST_NUM_BATCHES;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_GREEN:       min_green_q   <= cfg_wdata_i[TIME_W-1:0];
        CFG_MAX_GREEN:       max_green_q   <= cfg_wdata_i[TIME_W-1:0];
        CFG_YELLOW_TIME:     yellow_time_q <= cfg_wdata_i[TIME_W-1:0];
        CFG_RED_TIME:        red_time_q    <= cfg_wdata_i[TIME_W-1:0];
        CFG_RIGHT_TURN_MASK: right_mask_q  <= cfg_wdata_i[LINKS-1:0];
        CFG_NUM_LINKS:       num_links_q   <= cfg_wdata_i[CNT_W-1:0];
        CFG_NUM_BATCHES:     num_batches_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_INITIAL_STATE:   ;
        default:             ;
      endcase
    end
  end

  // batch masks: no reset; a row must be written before it is read, which the block does not enforce
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      batch_q[index_i[BATCH_IDX_W-1:0]] <= batch_mask_i[LINKS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LINKS; k++) begin
        delay_q[k] <= '0;
        veh_q[k]   <= '0;
      end
    end else if (cmd_i.report_we) begin
      delay_q[index_i[LINK_IDX_W-1:0]] <= link_delay_i[DW-1:0];
      veh_q[index_i[LINK_IDX_W-1:0]]   <= vehicle_count_i;
    end
  end

  // link sweep: every lane looks at the same link each cycle
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < BATCHES; b++) begin
      if (cmd_i.lanes_clr) begin
        lane_d_q[b]    <= '0;
        lane_ones_q[b] <= '0;
        lane_veh_q[b]  <= '0;
      end else if (cmd_i.lanes_acc && link_en[cmd_i.link_idx] &&
                   batch_q[b][cmd_i.link_idx]) begin
        lane_ones_q[b] <= lane_ones_q[b] + 1'b1;
        if (!right_mask_q[cmd_i.link_idx]) begin
          lane_d_q[b] <= lane_d_q[b] + SUM_W'(delay_q[cmd_i.link_idx]);
          if (veh_q[cmd_i.link_idx] > lane_veh_q[b]) begin
            lane_veh_q[b] <= veh_q[cmd_i.link_idx];
          end
        end
      end
    end
  end

  // batch compare: larger sum wins, then more links, then lower index
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en) begin
      if (cmd_i.cmp_first || (lane_d_q[cmd_i.batch_idx] > best_d_q) ||
          ((lane_d_q[cmd_i.batch_idx] == best_d_q) &&
           (lane_ones_q[cmd_i.batch_idx] > best_ones_q))) begin
        best_d_q    <= lane_d_q[cmd_i.batch_idx];
        best_ones_q <= lane_ones_q[cmd_i.batch_idx];
        best_veh_q  <= lane_veh_q[cmd_i.batch_idx];
        best_idx_q  <= cmd_i.batch_idx;
      end
    end
  end

  // green time: peak vehicles * min_green / 5, divide by reciprocal
  assign div_full = (PROD_W + 32)'(prod_q) * (PROD_W + 32)'(DIV5_MULT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(best_veh_q) * PROD_W'(min_green_q);
    end
    if (cmd_i.div_en) begin
      quo_q <= div_full[DIV5_SHIFT +: QUO_W];
    end
  end

  always_comb begin
    logic [QUO_W-1:0] g;
    g = quo_q;
    if (g < QUO_W'(min_green_q)) g = QUO_W'(min_green_q);
    if (g > QUO_W'(max_green_q)) g = QUO_W'(max_green_q);
    ngd_d = g[TIME_W-1:0];
    for (int k = 0; k < LINKS; k++) begin
      if (link_en[k] && batch_q[best_idx_q][k]) begin
        ngp_d[2*k +: 2] = right_mask_q[k] ? SIG_PERMISSIVE : SIG_GREEN;
      end else begin
        ngp_d[2*k +: 2] = SIG_RED;
      end
    end
  end

  // yellow end drops yellows to red; green end turns leaving greens yellow
  always_comb begin
    logic [1:0] c;
    need_yellow = 1'b0;
    for (int k = 0; k < LINKS; k++) begin
      c = cur_pat_q[2*k +: 2];
      yel_end_pat[2*k +: 2] = (link_en[k] && (c != SIG_YELLOW)) ? c : SIG_RED;
      if (link_en[k] && (c >= SIG_PERMISSIVE) && (ngp_q[2*k +: 2] == SIG_RED)) begin
        c           = SIG_YELLOW;
        need_yellow = 1'b1;
      end
      grn_end_pat[2*k +: 2] = link_en[k] ? c : SIG_RED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_phase_q  <= PH_GREEN;
      cur_pat_q    <= RST_INIT_STATE;
      ngp_q        <= '0;
      ngd_q        <= '0;
      last_batch_q <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= cmd_i.green_end || cmd_i.phase_adv;
      if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_INITIAL_STATE)) begin
        cur_pat_q <= cfg_wdata_i[PATTERN_W-1:0];
      end
      if (cmd_i.decide_en) begin
        ngp_q        <= ngp_d;
        ngd_q        <= ngd_d;
        last_batch_q <= best_idx_q;
      end
      if (cmd_i.green_end && need_yellow) begin
        cur_pat_q   <= grn_end_pat;
        cur_phase_q <= PH_YELLOW;
      end
      if (cmd_i.phase_adv) begin
        if (cur_phase_q == PH_YELLOW) begin
          cur_pat_q   <= yel_end_pat;
          cur_phase_q <= PH_RED;
        end else begin
          cur_pat_q   <= ngp_q;
          cur_phase_q <= PH_GREEN;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.green_end) begin
      chosen_q <= last_batch_q;
      if (need_yellow) begin
        shown_q <= grn_end_pat;
        dur_q   <= yellow_time_q;
        ph_q    <= PH_YELLOW;
        cont_q  <= 1'b0;
      end else begin
        shown_q <= cur_pat_q & lmask;
        dur_q   <= ngd_q;
        ph_q    <= PH_GREEN;
        cont_q  <= 1'b1;
      end
    end else if (cmd_i.phase_adv) begin
      chosen_q <= last_batch_q;
      cont_q   <= 1'b0;
      if (cur_phase_q == PH_YELLOW) begin
        shown_q <= yel_end_pat;
        dur_q   <= red_time_q;
        ph_q    <= PH_RED;
      end else begin
        shown_q <= ngp_q & lmask;
        dur_q   <= ngd_q;
        ph_q    <= PH_GREEN;
      end
    end
  end

  assign done_o            = done_q;
  assign signal_state_o    = shown_q;
  assign duration_o        = dur_q;
  assign phase_o           = ph_q;
  assign chosen_batch_o    = chosen_q;
  assign green_continued_o = cont_q;

endmodule

@@ src/max_delay_phase_signal_controller_top.sv @@
// Top level of the max-delay adaptive signal controller.
// Depends on mdpsc_pkg, mdpsc_ctrl and mdpsc_datapath.
`timescale 1ns / 1ps

// Max-delay adaptive signal controller. A beat is taken at a clock edge with
// start high and busy low. Batch loads (operation 0) and link reports
// (operation 1) are written in that one cycle and busy stays low; operation 3
// is dropped. An interval end (operation 2) makes exactly one result: done_o
// is high for one cycle with the result on the output ports, and the receiver
// cannot stall it, so capture it in that cycle. When the current phase is
// yellow or all red, busy is high for one cycle and the result shows in the
// next. When a green interval ends the block runs its decision, busy high
// throughout: the link sweep (one link per cycle over all 16 links, every
// batch summed in parallel lanes), the batch compare (one batch per cycle
// over the batches in use, num_batches clamped to 1..16) and the green-time
// multiply and divide by five. Times are in tenths of a second. The user
// must write configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i only
// while the block is idle; the block itself does not enforce it. Writing
// initial_state also loads the shown pattern. Batch rows power up undefined:
// load every batch in use before the first green decision.

module max_delay_phase_signal_controller_top import mdpsc_pkg::*; #(
  parameter int DELAY_WIDTH = 32  // stored bits of a link delay report
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // command beat
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             operation_i,
  input  logic [3:0]             index_i,
  input  logic [15:0]            batch_mask_i,
  input  logic [31:0]            link_delay_i,
  input  logic [7:0]             vehicle_count_i,
  // result beat
  output logic                   done_o,
  output logic [31:0]            signal_state_o,
  output logic [15:0]            duration_o,
  output logic [1:0]             phase_o,
  output logic [3:0]             chosen_batch_o,
  output logic                   green_continued_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: owns the link and batch counters
  mdpsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // tables, lanes, timing math, patterns and the result register
  mdpsc_datapath #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .index_i           (index_i),
    .batch_mask_i      (batch_mask_i),
    .link_delay_i      (link_delay_i),
    .vehicle_count_i   (vehicle_count_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .done_o            (done_o),
    .signal_state_o    (signal_state_o),
    .duration_o        (duration_o),
    .phase_o           (phase_o),
    .chosen_batch_o    (chosen_batch_o),
    .green_continued_o (green_continued_o)
  );

endmodule

@@ src/mdpsc_checker.sv @@
// Port-level assertions for the signal controller, bound to the top level.
// Depends on mdpsc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "max_delay_phase_signal_controller_top_macros.svh"

module mdpsc_checker import mdpsc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation_i,
  input logic       done_o,
  input logic [1:0] phase_o,
  input logic       green_continued_o
);

  logic end_beat, other_beat, kept_green;

  assign end_beat   = start && !busy && (operation_i == OP_INTERVAL_END);
  assign other_beat = start && !busy && (operation_i != OP_INTERVAL_END);
  assign kept_green = done_o && green_continued_o;

  // an interval end always occupies the block
  `MDPSC_ASSERT_NEXT(a_end_goes_busy, end_beat, busy, "interval end did not raise busy")
  // loads, reports and dropped codes never stall
  `MDPSC_ASSERT_NEXT(a_load_no_busy, other_beat, !busy, "non-interval beat raised busy")
  // a result only closes a busy span
  `MDPSC_ASSERT(a_done_after_busy, done_o |-> $past(busy), "result without preceding work")
  `MDPSC_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe held two cycles")
  // a kept green is always reported in green phase
  `MDPSC_ASSERT(a_cont_is_green, kept_green |-> (phase_o == PH_GREEN), "kept green off green")

endmodule

bind max_delay_phase_signal_controller_top mdpsc_checker u_mdpsc_checker (.*);

@@ test/tb_max_delay_phase_signal_controller_top.sv @@
// Self-checking testbench for max_delay_phase_signal_controller_top.
// Uses mdpsc_pkg for op, phase, signal and register codes.
// A built-in phase predictor checks each interval-end result.
`timescale 1ns / 1ps

module tb_max_delay_phase_signal_controller_top;
  import mdpsc_pkg::*;

  // Operation code that is not in op_e; the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One command beat as the sender drives it.
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [15:0] mask;
    logic [31:0] dly;
    logic [7:0]  veh;
  } ctl_cmd_t;

  // One interval result as the block should show it.
  typedef struct packed {
    logic [31:0] sig;
    logic [15:0] dur;
    logic [1:0]  ph;
    logic [3:0]  batch;
    logic        cont;
  } signal_result_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input has a known value from time 0.
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            operation_i = '0;
  logic [3:0]            index_i = '0;
  logic [15:0]           batch_mask_i = '0;
  logic [31:0]           link_delay_i = '0;
  logic [7:0]            vehicle_count_i = '0;
  logic                  done_o;
  logic [31:0]           signal_state_o;
  logic [15:0]           duration_o;
  logic [1:0]            phase_o;
  logic [3:0]            chosen_batch_o;
  logic                  green_continued_o;

  always #6 clk_i = ~clk_i;

  max_delay_phase_signal_controller_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start            (start),
    .busy             (busy),
    .operation_i      (operation_i),
    .index_i          (index_i),
    .batch_mask_i     (batch_mask_i),
    .link_delay_i     (link_delay_i),
    .vehicle_count_i  (vehicle_count_i),
    .done_o           (done_o),
    .signal_state_o   (signal_state_o),
    .duration_o       (duration_o),
    .phase_o          (phase_o),
    .chosen_batch_o   (chosen_batch_o),
    .green_continued_o(green_continued_o)
  );

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by stimulus, driver and monitor
  // ---------------------------------------------------------------------------
  ctl_cmd_t       pending_cmds[$];        // beats not yet driven
  signal_result_t expected_intervals[$];  // predicted results, oldest first
  int unsigned    queued_cnt   = 0;       // beats handed to the driver
  int unsigned    accepted_cnt = 0;       // beats the block has taken
  int unsigned    mismatches   = 0;
  bit             beat_taken   = 1'b0;    // start && !busy at the last rising edge
  bit             no_gaps      = 1'b0;    // tail of the run: sender never idles

  // Stimulus side: which batch rows hold a mask, and how many rows are in use.
  // An interval end is only queued once every row in use has been loaded,
  // since an unloaded row is undefined in the block.
  logic [15:0]    rows_loaded = '0;
  int unsigned    rows_in_use = 1;
  int unsigned    stim_count  = 0;

  // ---------------------------------------------------------------------------
  // Phase predictor: configuration copy and controller state
  // ---------------------------------------------------------------------------
  logic [15:0] min_g, max_g, yellow_t, red_t, rt_mask;
  logic [4:0]  n_links, n_batches;
  logic [31:0] init_pat;

  logic [15:0] batch_row [16];
  logic [31:0] link_dly  [16];
  logic [7:0]  link_veh  [16];
  phase_e      cur_phase;
  logic [31:0] cur_pattern;
  logic [31:0] next_pattern;
  logic [15:0] next_dur;
  logic [3:0]  last_pick;

  function automatic void reset_predictor();
    min_g     = RST_MIN_GREEN;
    max_g     = RST_MAX_GREEN;
    yellow_t  = RST_YELLOW_TIME;
    red_t     = RST_RED_TIME;
    rt_mask   = '0;
    n_links   = RST_NUM_LINKS;
    n_batches = RST_NUM_BATCHES;
    init_pat  = RST_INIT_STATE;
    for (int i = 0; i < 16; i++) begin
      batch_row[i] = '0;
      link_dly[i]  = '0;
      link_veh[i]  = '0;
    end
    cur_phase    = PH_GREEN;
    cur_pattern  = RST_INIT_STATE;
    next_pattern = '0;
    next_dur     = '0;
    last_pick    = '0;
  endfunction

  // Out-of-range counts: links saturate at 16, batches clamp to [1, 16].
  function automatic int unsigned links_used();
    return (n_links > 16) ? 16 : n_links;
  endfunction

  function automatic int unsigned batches_used();
    if (n_batches == 0) return 1;
    return (n_batches > 16) ? 16 : n_batches;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    case (cfg_idx_e'(idx))
      CFG_MIN_GREEN:       min_g = v[15:0];
      CFG_MAX_GREEN:       max_g = v[15:0];
      CFG_YELLOW_TIME:     yellow_t = v[15:0];
      CFG_RED_TIME:        red_t = v[15:0];
      CFG_RIGHT_TURN_MASK: rt_mask = v[15:0];
      CFG_NUM_LINKS:       n_links = v[4:0];
      CFG_NUM_BATCHES:     n_batches = v[4:0];
      CFG_INITIAL_STATE: begin
        init_pat    = v;
        cur_pattern = v;  // writing the start pattern also sets what is shown
      end
      default: ;
    endcase
  endfunction

  // Green decision: max non-right-turn delay sum, ties to more links, then to
  // the lower row. Green time scales the peak vehicle count by min_green/5.
  function automatic void pick_batch();
    int unsigned nl, nb, best, best_ones, best_veh, ones, veh, g, i, k;
    logic [63:0] best_sum, sum;
    nl = links_used();
    nb = batches_used();
    best_sum  = '0;
    best_ones = 0;
    best_veh  = 0;
    best      = 0;
    for (i = 0; i < nb; i++) begin
      sum  = '0;
      ones = 0;
      veh  = 0;
      for (k = 0; k < nl; k++) begin
        if (batch_row[i][k]) begin
          if (!rt_mask[k]) begin
            sum += link_dly[k];
            if (link_veh[k] > veh) veh = link_veh[k];
          end
          ones++;
        end
      end
      if (i == 0 || sum > best_sum || (sum == best_sum && ones > best_ones)) begin
        best_sum  = sum;
        best_ones = ones;
        best_veh  = veh;
        best      = i;
      end
    end
    last_pick = best[3:0];
    g = (best_veh * min_g) / 5;
    if (g < min_g) g = min_g;
    if (g > max_g) g = max_g;  // min above max ends at max_green
    next_dur = g[15:0];
    next_pattern = '0;
    for (k = 0; k < nl; k++) begin
      if (batch_row[best][k])
        next_pattern[2*k +: 2] = rt_mask[k] ? SIG_PERMISSIVE : SIG_GREEN;
    end
  endfunction

  // Advance the predictor by one accepted beat; returns 1 when a result is due.
  function automatic bit step_controller(input logic [1:0] op, input logic [3:0] idx,
                                         input logic [15:0] mask,
                                         input logic [31:0] dly, input logic [7:0] veh,
                                         output signal_result_t res);
    int unsigned nl, k;
    logic [31:0] lmask, p, shown;
    logic [1:0]  c;
    bit          need_yellow;
    res = '0;
    nl  = links_used();
    if (nl == 0) lmask = '0;
    else if (nl >= 16) lmask = '1;
    else lmask = (32'd1 << (2 * nl)) - 32'd1;

    case (op)
      OP_LOAD: begin
        batch_row[idx] = mask;
        return 1'b0;
      end
      OP_REPORT: begin
        link_dly[idx] = dly;
        link_veh[idx] = veh;
        return 1'b0;
      end
      OP_INTERVAL_END: ;
      default: return 1'b0;  // unused op is dropped
    endcase

    p = '0;
    if (cur_phase == PH_YELLOW) begin
      // yellow end: yellow links go red, everything else holds
      for (k = 0; k < nl; k++) begin
        c = cur_pattern[2*k +: 2];
        if (c == SIG_YELLOW) c = SIG_RED;
        p[2*k +: 2] = c;
      end
      cur_pattern = p;
      cur_phase   = PH_RED;
      shown       = p;
      res.dur     = red_t;
      res.ph      = PH_RED;
    end else if (cur_phase == PH_RED) begin
      // all-red end: the pending green takes over
      cur_pattern = next_pattern;
      cur_phase   = PH_GREEN;
      shown       = next_pattern;
      res.dur     = next_dur;
      res.ph      = PH_GREEN;
    end else begin
      pick_batch();
      need_yellow = 1'b0;
      for (k = 0; k < nl; k++) begin
        c = cur_pattern[2*k +: 2];
        if (c >= SIG_PERMISSIVE && next_pattern[2*k +: 2] == SIG_RED) begin
          c = SIG_YELLOW;
          need_yellow = 1'b1;
        end
        p[2*k +: 2] = c;
      end
      if (need_yellow) begin
        cur_pattern = p;
        cur_phase   = PH_YELLOW;
        shown       = p;
        res.dur     = yellow_t;
        res.ph      = PH_YELLOW;
      end else begin
        // green kept: the shown pattern stays exactly as it was
        shown    = cur_pattern;
        res.dur  = next_dur;
        res.ph   = PH_GREEN;
        res.cont = 1'b1;
      end
    end
    res.sig   = shown & lmask;
    res.batch = last_pick;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: results are checked, config writes and accepted beats are fed to
  // the predictor. Everything is sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    signal_result_t want, got;
    if (!rst_ni) begin
      reset_predictor();
      beat_taken = 1'b0;
    end else begin
      if (done_o !== 1'b0) begin
        got = '{signal_state_o, duration_o, phase_o, chosen_batch_o, green_continued_o};
        if (expected_intervals.size() == 0) begin
          $error("unexpected result beat: signal_state %h phase %0d", got.sig, got.ph);
          mismatches++;
        end else begin
          want = expected_intervals.pop_front();
          if (got.sig !== want.sig) begin
            $error("signal_state: expected %h, got %h", want.sig, got.sig);
            mismatches++;
          end
          if (got.dur !== want.dur) begin
            $error("duration: expected %0d, got %0d", want.dur, got.dur);
            mismatches++;
          end
          if (got.ph !== want.ph) begin
            $error("phase: expected %0d, got %0d", want.ph, got.ph);
            mismatches++;
          end
          if (got.batch !== want.batch) begin
            $error("chosen_batch: expected %0d, got %0d", want.batch, got.batch);
            mismatches++;
          end
          if (got.cont !== want.cont) begin
            $error("green_continued: expected %0d, got %0d", want.cont, got.cont);
            mismatches++;
          end
        end
      end
      if (cfg_we_i === 1'b1) apply_cfg(cfg_idx_i, cfg_wdata_i);
      beat_taken = (start === 1'b1) && (busy === 1'b0);
      if (beat_taken) begin
        accepted_cnt++;
        if (step_controller(operation_i, index_i, batch_mask_i, link_delay_i,
                            vehicle_count_i, want))
          expected_intervals.push_back(want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: one beat at a time from pending_cmds, launched on the falling edge.
  // A beat stays up until taken; after it, the sender may idle before the next one.
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    ctl_cmd_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !beat_taken) begin
      // hold the beat until the block takes it
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      start <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      nxt = pending_cmds.pop_front();
      operation_i     <= nxt.op;
      index_i         <= nxt.idx;
      batch_mask_i    <= nxt.mask;
      link_delay_i    <= nxt.dly;
      vehicle_count_i <= nxt.veh;
      start           <= 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 6);
    end else begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_delay();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 3);    // small values force ties
      3:       return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_veh();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(0, 10));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] rand_mask();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'd1 << $urandom_range(0, 15);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [3:0] idx, logic [15:0] mask,
                          logic [31:0] dly, logic [7:0] veh);
    ctl_cmd_t c;
    c = '{op, idx, mask, dly, veh};
    pending_cmds.push_back(c);
    queued_cnt++;
    if (op == OP_LOAD) rows_loaded[idx] = 1'b1;
    if (op != OP_UNUSED) stim_count++;
  endtask

  // Loads any row in use that was never written, then the interval end.
  task automatic push_interval_end();
    for (int r = 0; r < rows_in_use; r++) begin
      if (!rows_loaded[r]) push_cmd(OP_LOAD, r[3:0], rand_mask(), $urandom, 8'($urandom));
    end
    push_cmd(OP_INTERVAL_END, 4'($urandom_range(0, 15)), 16'($urandom), $urandom,
             8'($urandom));
  endtask

  task automatic push_report();
    push_cmd(OP_REPORT, 4'($urandom_range(0, 15)), 16'($urandom), rand_delay(), rand_veh());
  endtask

  task automatic push_load();
    push_cmd(OP_LOAD, 4'($urandom_range(0, 15)), rand_mask(), $urandom, 8'($urandom));
  endtask

  // Waits until every beat is taken and every result is in, then lets the
  // longest decision time pass so the block is surely idle.
  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_intervals.size() != 0)
      @(negedge clk_i);
    repeat (45) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
  endtask

  task automatic set_config(logic [15:0] mn, logic [15:0] mx, logic [15:0] yl,
                            logic [15:0] rd, logic [15:0] rt, logic [4:0] nl,
                            logic [4:0] nb, logic [31:0] init);
    write_reg(CFG_MIN_GREEN, 32'(mn));
    write_reg(CFG_MAX_GREEN, 32'(mx));
    write_reg(CFG_YELLOW_TIME, 32'(yl));
    write_reg(CFG_RED_TIME, 32'(rd));
    write_reg(CFG_RIGHT_TURN_MASK, 32'(rt));
    write_reg(CFG_NUM_LINKS, 32'(nl));
    write_reg(CFG_NUM_BATCHES, 32'(nb));
    write_reg(CFG_INITIAL_STATE, init);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    rows_in_use = (nb == 0) ? 1 : (nb > 16) ? 16 : nb;
  endtask

  // Mostly well-formed rounds (reports and loads, then interval ends), plus
  // bursts of interval ends that walk yellow, all-red and green in a row,
  // and some loose loads, reports and dropped-op noise.
  task automatic random_phase(int unsigned n);
    int unsigned sel;
    stim_count = 0;
    while (stim_count < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        repeat ($urandom_range(1, 4)) push_report();
        repeat ($urandom_range(0, 2)) push_load();
        repeat ($urandom_range(1, 3)) push_interval_end();
      end else if (sel < 70) begin
        repeat ($urandom_range(2, 5)) push_interval_end();
      end else if (sel < 85) begin
        if ($urandom_range(0, 1)) push_report();
        else push_load();
      end else if (sel < 95) begin
        repeat ($urandom_range(2, 6)) push_load();
      end else begin
        push_cmd(OP_UNUSED, 4'($urandom), 16'($urandom), $urandom, 8'($urandom));
      end
    end
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset config, pattern all red: first decisions keep green. Extreme
    // delay and count reports; the clamp to max_green; a dropped op.
    push_cmd(OP_LOAD, 4'd0, 16'h000F, '0, '0);
    push_interval_end();
    push_cmd(OP_REPORT, 4'd0, '0, 32'hFFFF_FFFF, 8'hFF);
    push_cmd(OP_REPORT, 4'd3, '0, 32'd1, 8'd5);
    push_cmd(OP_REPORT, 4'd15, '0, '0, '0);
    push_cmd(OP_UNUSED, 4'hF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    push_interval_end();
    drain();

    // All links green at start, min above max, link 1 a right turn, shortest
    // yellow and longest all-red: full yellow, red, green cycle, green kept,
    // tie broken by link count and then by the lower row.
    set_config(16'd700, 16'd500, 16'd1, 16'hFFFF, 16'h0002, 5'd16, 5'd2, 32'hFFFF_FFFF);
    push_cmd(OP_LOAD, 4'd0, 16'h0001, '0, '0);
    push_cmd(OP_LOAD, 4'd1, 16'h00F0, '0, '0);
    repeat (4) push_interval_end();
    push_cmd(OP_REPORT, 4'd0, '0, '0, '0);
    push_cmd(OP_LOAD, 4'd1, 16'h0003, '0, '0);
    push_interval_end();
    push_cmd(OP_LOAD, 4'd0, 16'h0003, '0, '0);
    push_interval_end();
    drain();

    // Random phases over a spread of settings.
    set_config(16'($urandom_range(1, 300)), 16'($urandom_range(100, 3000)),
               16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
               16'($urandom_range(0, 65535)), 5'($urandom_range(1, 16)),
               5'($urandom_range(1, 16)), $urandom);
    random_phase(180);

    set_config(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 5'd16, 5'd16, $urandom);
    random_phase(180);

    set_config(16'hFFFF, 16'hFFFF, 16'd30, 16'd20, 16'h0000, 5'd1, 5'd1, 32'hFFFF_FFFF);
    random_phase(150);

    // Counts outside the usual range: links saturate, zero batches means one.
    set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(0, 65535)), 5'd20, 5'd0, $urandom);
    random_phase(150);

    set_config(16'd100, 16'd600, 16'd30, 16'd20, 16'h00FF, 5'd0, 5'd31, 32'hAAAA_5555);
    random_phase(60);

    set_config(16'($urandom_range(1, 50)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(0, 65535)), 5'($urandom_range(1, 16)),
               5'($urandom_range(1, 16)), $urandom);
    random_phase(180);

    // Last stretch: sender never idles.
    set_config(16'($urandom_range(1, 200)), 16'($urandom_range(50, 5000)),
               16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
               16'($urandom_range(0, 65535)), 5'd16, 5'd16, $urandom);
    no_gaps = 1'b1;
    random_phase(180);

    if (mismatches == 0 && expected_intervals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
